@@ hw/rtl/gcr_pkg.sv @@
// Shared constants and types for the greedy rectangle cover block.
// Used by the candidate unit, the top-level sequencer and the checkers; depends on nothing.
package gcr_pkg;

  localparam int unsigned MaxRowsDef = 64;
  localparam int unsigned MaxColsDef = 64;

  localparam int unsigned DimW    = 7;
  localparam int unsigned AreaW   = 2 * DimW;
  localparam int unsigned PosW    = 6;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgRowsIdx = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgColsIdx = 2'd1;

  localparam logic [DimW-1:0] FrameResetVal = 7'd64;

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeFetch = 1'b1;

  typedef struct packed {
    logic clear_best;
    logic clear_run;
    logic step;
  } cand_ctl_t;

endpackage

@@ hw/rtl/gcr_row_mem.sv @@
// Row-wide image memory: one write port and one read port, read data registered.
// Stand-alone; no package dependency.
module gcr_row_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 64,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [Aw-1:0]    rd_addr_i,
  input  logic             wr_en_i,
  input  logic [Aw-1:0]    wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/gcr_cand.sv @@
// Shared candidate unit: column run length, area multiply and best-rectangle compare.
// Depends on gcr_pkg for widths and the control struct.
module gcr_cand #(
  parameter int unsigned RowAw = 6,
  parameter int unsigned ColAw = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gcr_pkg::cand_ctl_t        ctl_i,
  input  logic                      bit_i,
  input  logic [RowAw-1:0]          row_i,
  input  logic [ColAw-1:0]          col_i,
  input  logic [gcr_pkg::DimW-1:0]  height_i,
  output logic                      found_o,
  output logic [RowAw-1:0]          best_row_o,
  output logic [ColAw-1:0]          best_col_o,
  output logic [gcr_pkg::DimW-1:0]  best_height_o,
  output logic [gcr_pkg::DimW-1:0]  best_width_o
);

  logic [gcr_pkg::DimW-1:0]  run_q, run_d;
  logic [gcr_pkg::AreaW-1:0] best_area_q, area;
  logic                      found_q;
  logic [RowAw-1:0]          best_row_q;
  logic [ColAw-1:0]          best_col_q;
  logic [gcr_pkg::DimW-1:0]  best_h_q, best_w_q;
  logic                      better;

  assign run_d  = bit_i ? (run_q + gcr_pkg::DimW'(1)) : '0;
  assign area   = gcr_pkg::AreaW'(height_i) * gcr_pkg::AreaW'(run_d);
  assign better = bit_i && ((area > best_area_q) ||
                            ((area == best_area_q) && (row_i == best_row_q) &&
                             (col_i < best_col_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      best_area_q <= '0;
      found_q     <= 1'b0;
    end else begin
      if (ctl_i.clear_run) begin
        run_q <= '0;
      end else if (ctl_i.step) begin
        run_q <= run_d;
      end
      if (ctl_i.clear_best) begin
        best_area_q <= '0;
        found_q     <= 1'b0;
      end else if (ctl_i.step && better) begin
        best_area_q <= area;
        found_q     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step && better && !ctl_i.clear_best) begin
      best_row_q <= row_i;
      best_col_q <= col_i;
      best_h_q   <= height_i;
      best_w_q   <= run_d;
    end
  end

  assign found_o       = found_q;
  assign best_row_o    = best_row_q;
  assign best_col_o    = best_col_q;
  assign best_height_o = best_h_q;
  assign best_width_o  = best_w_q;

endmodule

@@ hw/rtl/greedy_rectangle_cover.sv @@
// Greedy rectangle cover of a binary image: top-level sequencer, config registers, output word.
// Depends on gcr_pkg, gcr_row_mem and gcr_cand.
//
// Each pixel keeps one free bit (set and not yet covered) in a row-wide memory of MAX_ROWS words
// of MAX_COLS bits. After reset a clearing pass zeroes every word of the memory; input is
// stalled meanwhile, configuration writes are taken at any time. A pixel write is a
// read-modify-write of its row after acceptance, or is dropped when it falls outside the frame. A
// fetch walks anchor rows r and grows rows i downward, AND-ing row words; for every (r, i) pair
// whose AND is non-zero the shared candidate unit visits the columns one per cycle. After the
// walk the block takes the winner, if any, reads and writes back each covered row to clear its
// free bits, and presents the result word, a done word when nothing was found.
module greedy_rectangle_cover #(
  parameter int unsigned MAX_ROWS = gcr_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = gcr_pkg::MaxColsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gcr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gcr_pkg::DimW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [gcr_pkg::PosW-1:0]    pixel_row_i,
  input  logic [gcr_pkg::PosW-1:0]    pixel_col_i,
  input  logic                        pixel_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [gcr_pkg::PosW-1:0]    rect_row_o,
  output logic [gcr_pkg::PosW-1:0]    rect_col_o,
  output logic [gcr_pkg::DimW-1:0]    rect_height_o,
  output logic [gcr_pkg::DimW-1:0]    rect_width_o,
  output logic                        done_res_o
);

  localparam int unsigned RowAw = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColAw = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned DimW  = gcr_pkg::DimW;
  localparam int unsigned PosW  = gcr_pkg::PosW;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WB,
    ST_F_RD,
    ST_F_AND,
    ST_F_SCAN,
    ST_CV_PREP,
    ST_CV_RD,
    ST_CV_WB,
    ST_RESULT
  } st_e;

  st_e                 state_q, state_d;
  logic [RowAw-1:0]    clr_q, clr_d;
  logic [RowAw-1:0]    r_q, r_d;
  logic [RowAw-1:0]    i_q, i_d;
  logic [ColAw-1:0]    c_q, c_d;
  logic [MAX_COLS-1:0] a_q, a_d;
  logic                first_q, first_d;
  logic [RowAw-1:0]    wr_row_q, wr_row_d;
  logic [ColAw-1:0]    wr_col_q, wr_col_d;
  logic                wr_val_q, wr_val_d;
  logic [MAX_COLS-1:0] mask_q, mask_d;
  logic [DimW-1:0]     rows_q, rows_d;
  logic [DimW-1:0]     cols_q, cols_d;
  logic                out_valid_q, out_valid_d;
  logic [PosW-1:0]     out_row_q, out_row_d;
  logic [PosW-1:0]     out_col_q, out_col_d;
  logic [DimW-1:0]     out_h_q, out_h_d;
  logic [DimW-1:0]     out_w_q, out_w_d;
  logic                out_done_q, out_done_d;

  logic [DimW-1:0]     m_eff, n_eff;
  logic [RowAw-1:0]    m_last;
  logic [MAX_COLS-1:0] col_mask, cov_mask, a_and, wr_word;
  logic [DimW-1:0]     h_now;
  logic                in_frame;

  logic                mem_re, mem_we;
  logic [RowAw-1:0]    mem_raddr, mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata, mem_rdata;

  gcr_pkg::cand_ctl_t  cand_ctl;
  logic                found;
  logic [RowAw-1:0]    best_row;
  logic [ColAw-1:0]    best_col;
  logic [DimW-1:0]     best_h, best_w;

  gcr_row_mem #(
    .Depth (MAX_ROWS),
    .Width (MAX_COLS)
  ) u_row_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_data_o (mem_rdata)
  );

  gcr_cand #(
    .RowAw (RowAw),
    .ColAw (ColAw)
  ) u_cand (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (cand_ctl),
    .bit_i         (a_q[c_q]),
    .row_i         (r_q),
    .col_i         (c_q),
    .height_i      (h_now),
    .found_o       (found),
    .best_row_o    (best_row),
    .best_col_o    (best_col),
    .best_height_o (best_h),
    .best_width_o  (best_w)
  );

  assign m_eff  = (32'(rows_q) > MAX_ROWS) ? DimW'(MAX_ROWS) : rows_q;
  assign n_eff  = (32'(cols_q) > MAX_COLS) ? DimW'(MAX_COLS) : cols_q;
  assign m_last = RowAw'(m_eff - DimW'(1));
  assign h_now  = DimW'(32'(i_q) - 32'(r_q) + 32'd1);

  assign in_frame = (DimW'(pixel_row_i) < m_eff) && (DimW'(pixel_col_i) < n_eff);

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      col_mask[j] = (j < 32'(n_eff));
      cov_mask[j] = (j >= 32'(best_col)) && (j < 32'(best_col) + 32'(best_w));
    end
  end

  assign a_and = (first_q ? {MAX_COLS{1'b1}} : a_q) & mem_rdata & col_mask;

  always_comb begin
    wr_word           = mem_rdata;
    wr_word[wr_col_q] = wr_val_q;
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == gcr_pkg::CfgRowsIdx) begin
        rows_d = cfg_data_i;
      end else if (cfg_index_i == gcr_pkg::CfgColsIdx) begin
        cols_d = cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    r_d         = r_q;
    i_d         = i_q;
    c_d         = c_q;
    a_d         = a_q;
    first_d     = first_q;
    wr_row_d    = wr_row_q;
    wr_col_d    = wr_col_q;
    wr_val_d    = wr_val_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_h_d     = out_h_q;
    out_w_d     = out_w_q;
    out_done_d  = out_done_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = i_q;
    mem_waddr   = i_q;
    mem_wdata   = mem_rdata & ~mask_q;
    cand_ctl    = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == RowAw'(MAX_ROWS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + RowAw'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == gcr_pkg::ModeWrite) begin
            wr_row_d = RowAw'(pixel_row_i);
            wr_col_d = ColAw'(pixel_col_i);
            wr_val_d = pixel_value_i;
            if (in_frame) begin
              state_d = ST_WR_RD;
            end
          end else begin
            cand_ctl.clear_best = 1'b1;
            r_d     = '0;
            i_d     = '0;
            first_d = 1'b1;
            if ((m_eff == '0) || (n_eff == '0)) begin
              state_d = ST_RESULT;
            end else begin
              state_d = ST_F_RD;
            end
          end
        end
      end
      ST_WR_RD: begin
        mem_re    = 1'b1;
        mem_raddr = wr_row_q;
        state_d   = ST_WR_WB;
      end
      ST_WR_WB: begin
        mem_we    = 1'b1;
        mem_waddr = wr_row_q;
        mem_wdata = wr_word;
        state_d   = ST_IDLE;
      end
      ST_F_RD: begin
        mem_re  = 1'b1;
        state_d = ST_F_AND;
      end
      ST_F_AND: begin
        a_d     = a_and;
        first_d = 1'b0;
        if (a_and == '0) begin
          if (r_q == m_last) begin
            state_d = ST_CV_PREP;
          end else begin
            r_d     = r_q + RowAw'(1);
            i_d     = r_q + RowAw'(1);
            first_d = 1'b1;
            state_d = ST_F_RD;
          end
        end else begin
          cand_ctl.clear_run = 1'b1;
          c_d     = ColAw'(n_eff - DimW'(1));
          state_d = ST_F_SCAN;
        end
      end
      ST_F_SCAN: begin
        cand_ctl.step = 1'b1;
        if (c_q == '0) begin
          if (i_q == m_last) begin
            if (r_q == m_last) begin
              state_d = ST_CV_PREP;
            end else begin
              r_d     = r_q + RowAw'(1);
              i_d     = r_q + RowAw'(1);
              first_d = 1'b1;
              state_d = ST_F_RD;
            end
          end else begin
            i_d     = i_q + RowAw'(1);
            state_d = ST_F_RD;
          end
        end else begin
          c_d = c_q - ColAw'(1);
        end
      end
      ST_CV_PREP: begin
        if (!found) begin
          state_d = ST_RESULT;
        end else begin
          mask_d  = cov_mask;
          r_d     = best_row;
          i_d     = best_row;
          state_d = ST_CV_RD;
        end
      end
      ST_CV_RD: begin
        mem_re  = 1'b1;
        state_d = ST_CV_WB;
      end
      ST_CV_WB: begin
        mem_we = 1'b1;
        if (h_now == best_h) begin
          state_d = ST_RESULT;
        end else begin
          i_d     = i_q + RowAw'(1);
          state_d = ST_CV_RD;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_row_d   = found ? PosW'(best_row) : '0;
          out_col_d   = found ? PosW'(best_col) : '0;
          out_h_d     = found ? best_h : '0;
          out_w_d     = found ? best_w : '0;
          out_done_d  = !found;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      r_q         <= '0;
      i_q         <= '0;
      c_q         <= '0;
      first_q     <= 1'b0;
      rows_q      <= gcr_pkg::FrameResetVal;
      cols_q      <= gcr_pkg::FrameResetVal;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_h_q     <= '0;
      out_w_q     <= '0;
      out_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      r_q         <= r_d;
      i_q         <= i_d;
      c_q         <= c_d;
      first_q     <= first_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      out_valid_q <= out_valid_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      out_h_q     <= out_h_d;
      out_w_q     <= out_w_d;
      out_done_q  <= out_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    wr_row_q <= wr_row_d;
    wr_col_q <= wr_col_d;
    wr_val_q <= wr_val_d;
    mask_q   <= mask_d;
  end

  assign out_valid_o   = out_valid_q;
  assign rect_row_o    = out_row_q;
  assign rect_col_o    = out_col_q;
  assign rect_height_o = out_h_q;
  assign rect_width_o  = out_w_q;
  assign done_res_o    = out_done_q;

endmodule

@@ hw/rtl/gcr_checker.sv @@
// Port-level checks for the greedy rectangle cover block, bound to the top level.
// Depends on gcr_pkg for field widths.
module gcr_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     mode_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [gcr_pkg::PosW-1:0] rect_row_o,
  input logic [gcr_pkg::PosW-1:0] rect_col_o,
  input logic [gcr_pkg::DimW-1:0] rect_height_o,
  input logic [gcr_pkg::DimW-1:0] rect_width_o,
  input logic                     done_res_o
);

  // keep a stalled result word valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |->
      (rect_row_o == '0) && (rect_col_o == '0) &&
      (rect_height_o == '0) && (rect_width_o == '0))
    else $error("done word carries a rectangle");

  a_rect_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> (rect_height_o != '0) && (rect_width_o != '0))
    else $error("rectangle word with empty size");

  // a pixel write never raises a result word
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == gcr_pkg::ModeWrite) |=> !$rose(out_valid_o))
    else $error("result word after a pixel write");

endmodule

bind greedy_rectangle_cover gcr_checker u_gcr_checker (.*);

@@ tb/gcr_checker.sv @@
// Checker for the greedy rectangle cover block: tracks the image, the covered marks and
// the frame registers from the observed channels, predicts each fetch and compares results.
// Depends on gcr_pkg for widths, register indexes and mode codes.
module tb_gcr_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [gcr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gcr_pkg::DimW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        mode_i,
  input  logic [gcr_pkg::PosW-1:0]    pixel_row_i,
  input  logic [gcr_pkg::PosW-1:0]    pixel_col_i,
  input  logic                        pixel_value_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [gcr_pkg::PosW-1:0]    rect_row_i,
  input  logic [gcr_pkg::PosW-1:0]    rect_col_i,
  input  logic [gcr_pkg::DimW-1:0]    rect_height_i,
  input  logic [gcr_pkg::DimW-1:0]    rect_width_i,
  input  logic                        done_res_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PosW        = gcr_pkg::PosW;
  localparam int unsigned DimW        = gcr_pkg::DimW;
  localparam int          Rows        = gcr_pkg::MaxRowsDef;
  localparam int          Cols        = gcr_pkg::MaxColsDef;
  localparam int          ReportLimit = 10;

  typedef struct packed {
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic [DimW-1:0] height;
    logic [DimW-1:0] width;
    logic            done;
  } rect_t;

  logic [Cols-1:0] image_q   [Rows];
  logic [Cols-1:0] covered_q [Rows];
  logic [DimW-1:0] frame_rows_q;
  logic [DimW-1:0] frame_cols_q;
  rect_t           rect_q [$];
  rect_t           got;
  rect_t           want;
  rect_t           next_rect;
  int              mismatches;
  int              frame_m;
  int              frame_n;

  function automatic int clip(input logic [DimW-1:0] v, input int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic logic is_free(input int r, input int c);
    return image_q[r][c] && !covered_q[r][c];
  endfunction

  function automatic rect_t greedy_round();
    int    m, n, best, lim, j, h, w;
    int    br, bc, bh, bw;
    rect_t pick;
    m = clip(frame_rows_q, Rows);
    n = clip(frame_cols_q, Cols);
    best = 0;
    br = 0;
    bc = 0;
    bh = 0;
    bw = 0;
    pick = '0;
    for (int r = 0; r < m; r++) begin
      for (int c = 0; c < n; c++) begin
        if (is_free(r, c)) begin
          lim = n;
          for (int i = r; i < m && is_free(i, c); i++) begin
            j = c;
            while (j < lim && is_free(i, j)) j++;
            lim = j;
            h = i - r + 1;
            w = lim - c;
            if (h * w > best) begin
              best = h * w;
              br = r;
              bc = c;
              bh = h;
              bw = w;
            end
          end
        end
      end
    end
    if (best == 0) begin
      pick.done = 1'b1;
    end else begin
      for (int i = br; i < br + bh; i++)
        for (int k = bc; k < bc + bw; k++)
          covered_q[i][k] = 1'b1;
      pick.row    = PosW'(br);
      pick.col    = PosW'(bc);
      pick.height = DimW'(bh);
      pick.width  = DimW'(bw);
    end
    return pick;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Rows; r++) begin
        image_q[r]   = '0;
        covered_q[r] = '0;
      end
      frame_rows_q = gcr_pkg::FrameResetVal;
      frame_cols_q = gcr_pkg::FrameResetVal;
      rect_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          gcr_pkg::CfgRowsIdx: frame_rows_q = cfg_data_i;
          gcr_pkg::CfgColsIdx: frame_cols_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (mode_i == gcr_pkg::ModeWrite) begin
          frame_m = clip(frame_rows_q, Rows);
          frame_n = clip(frame_cols_q, Cols);
          if (int'(pixel_row_i) < frame_m && int'(pixel_col_i) < frame_n) begin
            image_q[pixel_row_i][pixel_col_i]   = pixel_value_i;
            covered_q[pixel_row_i][pixel_col_i] = 1'b0;
          end
        end else begin
          next_rect = greedy_round();
          rect_q    = {rect_q, next_rect};
        end
      end
      if (out_valid_i && !out_stall_i) begin
        got.row    = rect_row_i;
        got.col    = rect_col_i;
        got.height = rect_height_i;
        got.width  = rect_width_i;
        got.done   = done_res_i;
        if (rect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%0t: unexpected rectangle word row %0d col %0d h %0d w %0d done %0d",
                     $realtime, got.row, got.col, got.height, got.width, got.done);
        end else begin
          want = rect_q.pop_front();
          if (got.row !== want.row || got.col !== want.col || got.height !== want.height ||
              got.width !== want.width || got.done !== want.done) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display("%0t: mismatch exp r%0d c%0d h%0d w%0d d%0d got r%0d c%0d h%0d w%0d d%0d",
                       $realtime, want.row, want.col, want.height, want.width, want.done,
                       got.row, got.col, got.height, got.width, got.done);
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= rect_q.size();
  end

endmodule

@@ tb/tb_greedy_rectangle_cover.sv @@
// Testbench top for the greedy rectangle cover block: clock, reset, pixel and fetch stimulus,
// frame register writes, receiver stalls and the verdict. Depends on gcr_pkg, the block and
// tb_gcr_checker, which does all prediction and comparison.
module tb_greedy_rectangle_cover;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CfgIdxW = gcr_pkg::CfgIdxW;
  localparam int unsigned DimW    = gcr_pkg::DimW;
  localparam int unsigned PosW    = gcr_pkg::PosW;

  localparam int QuietLimit  = 1000000;
  localparam int ResetCycles = 6;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 8;
  localparam int TailCycles  = 32;
  localparam int PhaseItems  = 10;

  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTopIdx   = 2'd3;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [DimW-1:0]    cfg_data_i    = '0;
  logic               in_valid_i    = 1'b0;
  logic               mode_i        = gcr_pkg::ModeWrite;
  logic [PosW-1:0]    pixel_row_i   = '0;
  logic [PosW-1:0]    pixel_col_i   = '0;
  logic               pixel_value_i = 1'b0;
  logic               out_stall_i   = 1'b0;
  logic               cfg_ready_o;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [PosW-1:0]    rect_row_o;
  logic [PosW-1:0]    rect_col_o;
  logic [DimW-1:0]    rect_height_o;
  logic [DimW-1:0]    rect_width_o;
  logic               done_res_o;

  int fail_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  greedy_rectangle_cover DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rect_row_o    (rect_row_o),
    .rect_col_o    (rect_col_o),
    .rect_height_o (rect_height_o),
    .rect_width_o  (rect_width_o),
    .done_res_o    (done_res_o)
  );

  tb_gcr_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .mode_i        (mode_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .pixel_value_i (pixel_value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rect_row_i    (rect_row_o),
    .rect_col_i    (rect_col_o),
    .rect_height_i (rect_height_o),
    .rect_width_i  (rect_width_o),
    .done_res_i    (done_res_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen   <= hold_token;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("** greedy_rectangle_cover: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic m, input int r, input int c, input logic v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    pixel_row_i   <= PosW'(r);
    pixel_col_i   <= PosW'(c);
    pixel_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic put_pixel(input int r, input int c, input logic v);
    send_word(gcr_pkg::ModeWrite, r, c, v);
  endtask

  task automatic fetch_rect();
    send_word(gcr_pkg::ModeFetch, $urandom_range(63), $urandom_range(63), $urandom_range(1));
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input int data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= DimW'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(input int rows, input int cols);
    cfg_write(gcr_pkg::CfgRowsIdx, rows);
    cfg_write(gcr_pkg::CfgColsIdx, cols);
  endtask

  // drop the input, drain every outstanding rectangle, let a last pixel write finish
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic scramble_frame(input int rows, input int cols, input int budget);
    int sent, nw, nf, bh, bw, br, bc;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(2) == 0) begin
        bh = $urandom_range(rows < 3 ? rows : 3, 1);
        bw = $urandom_range(cols < 3 ? cols : 3, 1);
        br = $urandom_range(rows - bh);
        bc = $urandom_range(cols - bw);
        for (int i = 0; i < bh; i++)
          for (int k = 0; k < bw; k++)
            put_pixel(br + i, bc + k, 1'b1);
        sent += bh * bw;
      end
      nw = $urandom_range(6, 1);
      for (int k = 0; k < nw; k++) begin
        if ($urandom_range(99) < 85)
          put_pixel($urandom_range(rows - 1), $urandom_range(cols - 1), $urandom_range(99) < 80);
        else
          put_pixel($urandom_range(63), $urandom_range(63), $urandom_range(1));
      end
      nf = $urandom_range(3, 1);
      for (int k = 0; k < nf; k++) fetch_rect();
      sent += nw + nf;
    end
  endtask

  initial begin
    int rows, cols;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty image, corners, scattered single pixels and a solid block
    fetch_rect();
    put_pixel(0, 0, 1'b1);
    put_pixel(0, 63, 1'b1);
    put_pixel(63, 0, 1'b1);
    put_pixel(63, 63, 1'b1);
    put_pixel(42, 21, 1'b1);
    put_pixel(21, 42, 1'b0);
    for (int i = 10; i < 12; i++)
      for (int k = 5; k < 8; k++)
        put_pixel(i, k, 1'b1);
    fetch_rect();
    put_pixel(11, 6, 1'b1);
    repeat (6) fetch_rect();

    // empty frame, oversized registers, spare indexes, shrunk frame
    settle();
    set_frame(0, 64);
    put_pixel(0, 0, 1'b1);
    fetch_rect();
    settle();
    set_frame(100, 127);
    cfg_write(CfgSpareIdx, 3);
    cfg_write(CfgTopIdx, 127);
    put_pixel(0, 0, 1'b1);
    put_pixel(5, 5, 1'b1);
    fetch_rect();
    settle();
    set_frame(2, 2);
    put_pixel(1, 0, 1'b1);
    put_pixel(3, 0, 1'b1);
    fetch_rect();
    fetch_rect();

    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 2; s++) begin
        settle();
        case (p)
          0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
          1: begin send_idle_pct = 88; recv_stall_pct <= 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct <= 88; end
          default: begin send_idle_pct = 23; recv_stall_pct <= 23; end
        endcase
        case (p * 2 + s)
          0: begin rows = 6;  cols = 9;  end
          1: begin rows = 64; cols = 64; end
          2: begin rows = 1;  cols = 64; end
          3: begin rows = $urandom_range(12, 2); cols = $urandom_range(12, 2); end
          4: begin rows = 64; cols = 1;  end
          5: begin rows = 12; cols = 12; end
          6: begin rows = 16; cols = 16; end
          default: begin rows = 1; cols = 1; end
        endcase
        set_frame(rows, cols);
        if (p == 0 && s == 0) begin
          hold_token <= hold_token + 1;
          for (int k = 0; k < 4; k++)
            put_pixel($urandom_range(rows - 1), $urandom_range(cols - 1), 1'b1);
          repeat (8) fetch_rect();
        end
        scramble_frame(rows, cols, PhaseItems);
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0)
      $display("** greedy_rectangle_cover: PASSED **");
    else
      $display("** greedy_rectangle_cover: FAILED **");
    $finish;
  end

endmodule

@@ greedy_rectangle_cover.f @@
hw/rtl/gcr_pkg.sv
hw/rtl/gcr_row_mem.sv
hw/rtl/gcr_cand.sv
hw/rtl/greedy_rectangle_cover.sv
hw/rtl/gcr_checker.sv
tb/gcr_checker.sv
tb/tb_greedy_rectangle_cover.sv
